// ----- hdl/hac_pkg.sv -----
// Shared types and constants for the heading alignment cost block.
// Used by hac_ctrl, hac_dp and heading_alignment_cost; no dependencies.
package hac_pkg;

  // Trajectory length limit and derived count width
  localparam int unsigned MAX_STEPS = 64;
  localparam int unsigned CNT_W     = $clog2(MAX_STEPS + 1);
  localparam int unsigned STEPS_W   = 7;

  // Fixed-point constants
  localparam int unsigned EPS_Q16   = 66;     // 0.001 in Q16.16
  localparam int unsigned ONE_Q14   = 16384;  // 1.0 in Q2.14
  localparam int unsigned WEIGHT_RST = 3840;  // 15.0 in Q8.8

  // Datapath widths
  localparam int unsigned DOT_W = 50;
  localparam int unsigned DVS_W = 34;
  localparam int unsigned QUO_W = 24;
  localparam int unsigned IDX_W = 5;

  // Iteration start indices
  localparam logic [IDX_W-1:0] SQRT_TOP  = 5'd31;
  localparam logic [IDX_W-1:0] ALIGN_TOP = 5'd15;
  localparam logic [IDX_W-1:0] MEAN_TOP  = 5'd23;

  // Configuration register indices
  localparam logic [2:0] REG_WEIGHT    = 3'd0;
  localparam logic [2:0] REG_HEADING_X = 3'd1;
  localparam logic [2:0] REG_HEADING_Y = 3'd2;
  localparam logic [2:0] REG_HDG_VALID = 3'd3;
  localparam logic [2:0] REG_ENABLED   = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIFF,
    OP_MAG,
    OP_MXX,
    OP_MYY,
    OP_DXH,
    OP_DYH,
    OP_SQRT,
    OP_DINIT,
    OP_DIV,
    OP_ACCUM,
    OP_MINIT,
    OP_COST
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_MAG,
    S_MXX,
    S_MYY,
    S_DXH,
    S_DYH,
    S_SQRT,
    S_DINIT,
    S_DIV,
    S_ACCUM,
    S_CHECK,
    S_MINIT,
    S_MDIV,
    S_COST,
    S_EMIT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e           op;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_ok;
    logic last;
    logic cost_go;
  } dp_stat_t;

endpackage

// ----- hdl/heading_alignment_cost.sv -----
// Heading alignment cost: each point is taken through a bit-serial square
// root and a divide; points beyond the step limit skip both. A last point
// adds a mean divide with its set-up when the block is enabled, the heading
// is valid and the count is nonzero, then the cost step; the next point may
// be taken once the result register is loaded. One point in flight at a time; the result
// register frees the block once loaded. Reset (async, active low) restores
// the register defaults and clears the trajectory start, sum and count.
module heading_alignment_cost (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_index_i,
  input  logic [15:0]                 cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [31:0]          pos_x_i,
  input  logic signed [31:0]          pos_y_i,
  input  logic                        first_point_i,
  input  logic                        last_point_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [31:0]                 cost_add_o,
  output logic [hac_pkg::STEPS_W-1:0] steps_used_o
);
  import hac_pkg::*;

  logic [15:0]        weight_q;
  logic signed [15:0] hdg_x_q, hdg_y_q;
  logic               hdg_valid_q, enabled_q;
  logic               out_valid_q;
  logic [31:0]        cost_add_q;
  logic [STEPS_W-1:0] steps_used_q;
  logic               out_free, emit;
  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [31:0]        dp_cost;
  logic [STEPS_W-1:0] dp_steps;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q    <= 16'(WEIGHT_RST);
      hdg_x_q     <= '0;
      hdg_y_q     <= '0;
      hdg_valid_q <= 1'b0;
      enabled_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WEIGHT:    weight_q    <= cfg_data_i;
        REG_HEADING_X: hdg_x_q     <= $signed(cfg_data_i);
        REG_HEADING_Y: hdg_y_q     <= $signed(cfg_data_i);
        REG_HDG_VALID: hdg_valid_q <= cfg_data_i[0];
        REG_ENABLED:   enabled_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Result register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      cost_add_q   <= dp_cost;
      steps_used_q <= dp_steps;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cost_add_o   = cost_add_q;
  assign steps_used_o = steps_used_q;

  hac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_free_i (out_free),
    .emit_o     (emit),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hac_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .first_point_i   (first_point_i),
    .last_point_i    (last_point_i),
    .weight_i        (weight_q),
    .heading_x_i     (hdg_x_q),
    .heading_y_i     (hdg_y_q),
    .heading_valid_i (hdg_valid_q),
    .enabled_i       (enabled_q),
    .cost_o          (dp_cost),
    .steps_o         (dp_steps)
  );

endmodule

// ----- hdl/hac_ctrl.sv -----
// Sequencing controller for the heading alignment cost block.
// Depends on hac_pkg; drives hac_dp through command and status structs.
module hac_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_free_i,
  output logic              emit_o,
  input  hac_pkg::dp_stat_t stat_i,
  output hac_pkg::dp_cmd_t  cmd_o
);
  import hac_pkg::*;

  ctrl_state_e      state_q, state_d;
  logic [IDX_W-1:0] it_q, it_d;

  // State and iteration counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      it_q    <= '0;
    end else begin
      state_q <= state_d;
      it_q    <= it_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    it_d    = it_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_DIFF;
      S_DIFF:  state_d = stat_i.cnt_ok ? S_MAG : S_CHECK;
      S_MAG:   state_d = S_MXX;
      S_MXX:   state_d = S_MYY;
      S_MYY:   state_d = S_DXH;
      S_DXH:   state_d = S_DYH;
      S_DYH: begin
        state_d = S_SQRT;
        it_d    = SQRT_TOP;
      end
      S_SQRT: begin
        if (it_q == '0) state_d = S_DINIT;
        else it_d = it_q - 1'b1;
      end
      S_DINIT: begin
        state_d = S_DIV;
        it_d    = ALIGN_TOP;
      end
      S_DIV: begin
        if (it_q == '0) state_d = S_ACCUM;
        else it_d = it_q - 1'b1;
      end
      S_ACCUM: state_d = S_CHECK;
      S_CHECK: begin
        if (!stat_i.last) state_d = S_IDLE;
        else if (stat_i.cost_go) state_d = S_MINIT;
        else state_d = S_COST;
      end
      S_MINIT: begin
        state_d = S_MDIV;
        it_d    = MEAN_TOP;
      end
      S_MDIV: begin
        if (it_q == '0) state_d = S_COST;
        else it_d = it_q - 1'b1;
      end
      S_COST:  state_d = S_EMIT;
      S_EMIT:  if (out_free_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o.op   = OP_NONE;
    cmd_o.idx  = it_q;
    in_ready_o = 1'b0;
    emit_o     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      S_DIFF:  cmd_o.op = OP_DIFF;
      S_MAG:   cmd_o.op = OP_MAG;
      S_MXX:   cmd_o.op = OP_MXX;
      S_MYY:   cmd_o.op = OP_MYY;
      S_DXH:   cmd_o.op = OP_DXH;
      S_DYH:   cmd_o.op = OP_DYH;
      S_SQRT:  cmd_o.op = OP_SQRT;
      S_DINIT: cmd_o.op = OP_DINIT;
      S_DIV:   cmd_o.op = OP_DIV;
      S_ACCUM: cmd_o.op = OP_ACCUM;
      S_CHECK: cmd_o.op = OP_NONE;
      S_MINIT: cmd_o.op = OP_MINIT;
      S_MDIV:  cmd_o.op = OP_DIV;
      S_COST:  cmd_o.op = OP_COST;
      S_EMIT:  emit_o = out_free_i;
      default: cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// ----- hdl/hac_dp.sv -----
// Datapath: trajectory state, shared multiplier, bit-serial root and divider.
// Depends on hac_pkg; commanded one step per cycle by hac_ctrl.
module hac_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hac_pkg::dp_cmd_t            cmd_i,
  output hac_pkg::dp_stat_t           stat_o,
  input  logic signed [31:0]          pos_x_i,
  input  logic signed [31:0]          pos_y_i,
  input  logic                        first_point_i,
  input  logic                        last_point_i,
  input  logic [15:0]                 weight_i,
  input  logic signed [15:0]          heading_x_i,
  input  logic signed [15:0]          heading_y_i,
  input  logic                        heading_valid_i,
  input  logic                        enabled_i,
  output logic [31:0]                 cost_o,
  output logic [hac_pkg::STEPS_W-1:0] steps_o
);
  import hac_pkg::*;

  // Trajectory state
  logic signed [31:0] sx_q, sy_q;
  logic signed [23:0] sum_q;
  logic [CNT_W-1:0]   cnt_q;

  // Per-point working registers
  logic signed [31:0]       px_q, py_q;
  logic                     last_q;
  logic signed [32:0]       dx_q, dy_q;
  logic [31:0]              mx_q, my_q;
  logic                     big_q;
  logic [63:0]              rad_q;
  logic signed [DOT_W-1:0]  dot_q;
  logic [63:0]              sq_rem_q, sq_res_q, sq_bit_q;
  logic [DOT_W-1:0]         drem_q;
  logic [DVS_W-1:0]         dvs_q;
  logic [QUO_W-1:0]         dq_q;
  logic                     neg_q;
  logic [31:0]              cost_q;
  logic [STEPS_W-1:0]       steps_q;

  // Status
  assign stat_o.cnt_ok  = (cnt_q < CNT_W'(MAX_STEPS));
  assign stat_o.last    = last_q;
  assign stat_o.cost_go = enabled_i & heading_valid_i & (cnt_q != '0);
  assign cost_o  = cost_q;
  assign steps_o = steps_q;

  // Magnitudes, with halving for large displacements
  logic [32:0]        ndx, ndy, nhx, nhy;
  logic signed [32:0] hx, hy;
  logic [31:0]        ax, ay, amx, amy;
  always_comb begin
    ndx = 33'(-dx_q);
    ndy = 33'(-dy_q);
    ax  = dx_q[32] ? ndx[31:0] : dx_q[31:0];
    ay  = dy_q[32] ? ndy[31:0] : dy_q[31:0];
    hx  = dx_q >>> 1;
    hy  = dy_q >>> 1;
    nhx = 33'(-hx);
    nhy = 33'(-hy);
    amx = hx[32] ? nhx[31:0] : hx[31:0];
    amy = hy[32] ? nhy[31:0] : hy[31:0];
  end

  // Shared multiplier
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      OP_MXX: begin ma = $signed({1'b0, mx_q}); mb = $signed({1'b0, mx_q}); end
      OP_MYY: begin ma = $signed({1'b0, my_q}); mb = $signed({1'b0, my_q}); end
      OP_DXH: begin ma = dx_q; mb = 33'(heading_x_i); end
      OP_DYH: begin ma = dy_q; mb = 33'(heading_y_i); end
      default: begin ma = '0; mb = '0; end
    endcase
    prod = ma * mb;
  end

  // Square root step
  logic [63:0] sq_trial;
  logic        sq_ge;
  assign sq_trial = sq_res_q + sq_bit_q;
  assign sq_ge    = (sq_rem_q >= sq_trial);

  // Restoring divide step
  logic [56:0] dsh;
  logic        d_ge;
  assign dsh  = {23'b0, dvs_q} << cmd_i.idx;
  assign d_ge = ({7'b0, drem_q} >= dsh);

  // Divider set-up values
  logic [32:0]      dlen;
  logic [DOT_W-1:0] ndot;
  logic [23:0]      nsum;
  assign dlen = big_q ? {sq_res_q[31:0], 1'b0} : {1'b0, sq_res_q[31:0]};
  assign ndot = DOT_W'(-dot_q);
  assign nsum = 24'(-sum_q);

  // Alignment saturation and running sum
  logic [15:0]        q16;
  logic signed [15:0] align;
  logic signed [24:0] s25;
  logic signed [23:0] sum_sat;
  always_comb begin
    q16 = dq_q[15:0];
    if (neg_q) align = q16[15] ? 16'sh8000 : 16'(-q16);
    else align = (q16 >= 16'd32767) ? 16'sh7fff : $signed(q16);
    s25 = 25'(sum_q) + 25'(align);
    if (s25[24] != s25[23]) sum_sat = s25[24] ? 24'sh800000 : 24'sh7fffff;
    else sum_sat = s25[23:0];
  end

  // Cost from mean alignment
  logic signed [24:0] mean;
  logic signed [25:0] diff;
  logic [39:0]        wprod;
  logic [33:0]        cshift;
  logic [31:0]        cost_d;
  always_comb begin
    mean   = neg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
    diff   = 26'(ONE_Q14) - 26'(mean);
    wprod  = 40'(weight_i) * 40'(diff[23:0]);
    cshift = 34'(wprod >> 6);
    cost_d = '0;
    if (stat_o.cost_go && !diff[25] && (diff != '0)) begin
      cost_d = (cshift[33:32] != 2'b00) ? 32'hffff_ffff : cshift[31:0];
    end
  end

  // Trajectory state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q  <= '0;
      sy_q  <= '0;
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      case (cmd_i.op)
        OP_LOAD: begin
          if (first_point_i) begin
            sx_q  <= pos_x_i;
            sy_q  <= pos_y_i;
            sum_q <= '0;
            cnt_q <= '0;
          end
        end
        OP_ACCUM: begin
          sum_q <= sum_sat;
          cnt_q <= cnt_q + 1'b1;
        end
        OP_COST: begin
          sum_q <= '0;
          cnt_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        px_q   <= pos_x_i;
        py_q   <= pos_y_i;
        last_q <= last_point_i;
      end
      OP_DIFF: begin
        dx_q <= 33'(px_q) - 33'(sx_q);
        dy_q <= 33'(py_q) - 33'(sy_q);
      end
      OP_MAG: begin
        big_q <= ax[31] | ay[31];
        mx_q  <= (ax[31] | ay[31]) ? amx : ax;
        my_q  <= (ax[31] | ay[31]) ? amy : ay;
      end
      OP_MXX: rad_q <= prod[63:0];
      OP_MYY: rad_q <= rad_q + prod[63:0];
      OP_DXH: begin
        dot_q    <= prod[DOT_W-1:0];
        sq_rem_q <= rad_q;
        sq_res_q <= '0;
        sq_bit_q <= 64'h4000_0000_0000_0000;
      end
      OP_DYH: dot_q <= dot_q + prod[DOT_W-1:0];
      OP_SQRT: begin
        if (sq_ge) begin
          sq_rem_q <= sq_rem_q - sq_trial;
          sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
      end
      OP_DINIT: begin
        dvs_q  <= DVS_W'(dlen) + DVS_W'(EPS_Q16);
        drem_q <= dot_q[DOT_W-1] ? ndot : dot_q;
        dq_q   <= '0;
        neg_q  <= dot_q[DOT_W-1];
      end
      OP_DIV: begin
        if (d_ge) begin
          drem_q           <= drem_q - dsh[DOT_W-1:0];
          dq_q[cmd_i.idx]  <= 1'b1;
        end
      end
      OP_MINIT: begin
        dvs_q  <= DVS_W'(cnt_q);
        drem_q <= DOT_W'(sum_q[23] ? nsum : sum_q);
        dq_q   <= '0;
        neg_q  <= sum_q[23];
      end
      OP_COST: begin
        cost_q  <= cost_d;
        steps_q <= STEPS_W'(cnt_q);
      end
      default: ;
    endcase
  end

endmodule
